// ----- rtl/core/bfph_pkg.sv -----
// bfph_pkg: shared types, constants and helpers of the string bloom filter
package bfph_pkg;

  localparam int unsigned DEF_MAX_FILTER_BITS = 65536;
  localparam int unsigned DEF_MAX_HASHES      = 4;

  localparam int unsigned SIZE_W      = 17;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned BASE_W      = 16;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned NUM_BASES   = 4;

  // remainder bits retired per cycle in the modulo unit
  localparam int unsigned MOD_STEPS = 8;

  localparam logic [SIZE_W-1:0]  RST_FILTER_SIZE = SIZE_W'(65536);
  localparam logic [COUNT_W-1:0] RST_HASH_COUNT  = COUNT_W'(1);
  localparam logic [BASE_W-1:0]  RST_BASE_ZERO   = BASE_W'(31);
  localparam logic [BASE_W-1:0]  RST_BASE_ONE    = BASE_W'(37);
  localparam logic [BASE_W-1:0]  RST_BASE_TWO    = BASE_W'(41);
  localparam logic [BASE_W-1:0]  RST_BASE_THREE  = BASE_W'(43);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FILTER_SIZE,
    REG_HASH_COUNT,
    REG_BASE_ZERO,
    REG_BASE_ONE,
    REG_BASE_TWO,
    REG_BASE_THREE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_GO,
    ST_MOD,
    ST_DONE,
    ST_OUT
  } state_t;

  function automatic int unsigned aw_of(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- rtl/core/bfph_ram.sv -----
// bfph_ram: generic simple dual-port ram with registered read
module bfph_ram import bfph_pkg::*; #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [aw_of(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [aw_of(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bfph_mod.sv -----
// bfph_mod: iterative remainder unit, several restoring steps per cycle
module bfph_mod import bfph_pkg::*; #(
  parameter int unsigned DVD_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] modulus,
  output logic              busy,
  output logic [SIZE_W-1:0] remainder
);

  localparam int unsigned NCYC  = DVD_W / MOD_STEPS;
  localparam int unsigned CNT_W = aw_of(NCYC + 1);

  logic [DVD_W-1:0]  dvd, dvd_v;
  logic [SIZE_W-1:0] rem, rem_v;
  logic [SIZE_W:0]   t;
  logic [CNT_W-1:0]  cnt;

  always_comb begin
    rem_v = rem;
    dvd_v = dvd;
    t     = '0;
    for (int i = 0; i < MOD_STEPS; i++) begin
      t     = {rem_v, dvd_v[DVD_W-1]};
      dvd_v = {dvd_v[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      rem_v = t[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NCYC);
      dvd  <= dividend;
      rem  <= '0;
    end else if (busy) begin
      dvd <= dvd_v;
      rem <= rem_v;
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign remainder = rem;

endmodule

// ----- rtl/core/bloom_filter_poly_hash.sv -----
// bloom_filter_poly_hash: string bloom filter with polynomial hashes, top level
// a character is processed one hash after another, each hash a read-modify-write of the hash
// state memory around the modulo units, through the states ST_MUL, ST_GO and ST_MOD
// throughput: one character at a time; the last one of a string adds ST_DONE and ST_OUT, where
// a query waits for a free output register, which holds the result as new characters are taken
// reset: synchronous; the filter memory is then cleared one bit a cycle, all of its bits
module bloom_filter_poly_hash import bfph_pkg::*; #(
  parameter int unsigned MAX_FILTER_BITS = DEF_MAX_FILTER_BITS,
  parameter int unsigned MAX_HASHES      = DEF_MAX_HASHES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic [CHAR_W-1:0]      char_code,
  input  logic                   last_char,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   maybe_present
);

  localparam int unsigned AW    = aw_of(MAX_FILTER_BITS);
  localparam int unsigned HW    = (AW < SIZE_W) ? AW : SIZE_W;
  localparam int unsigned KW    = aw_of(MAX_HASHES);
  localparam int unsigned DVD_W = ((HW + BASE_W + MOD_STEPS - 1) / MOD_STEPS) * MOD_STEPS;

  state_t state, state_next;

  logic [SIZE_W-1:0]  filter_size;
  logic [COUNT_W-1:0] hash_count;
  logic [BASE_W-1:0]  base [NUM_BASES];
  logic [SIZE_W-1:0]  eff_m;
  logic [COUNT_W-1:0] eff_cnt;

  logic              op, lst, fresh, all_set, chk_pend;
  logic [CHAR_W-1:0] chr;
  logic [KW-1:0]     k, k_inc;
  logic              k_last, use_k;
  logic [AW-1:0]     clr_addr;

  logic accept, wb, mod_start, load_out, fil_hit;

  logic [2*HW-1:0] hram_rdata, hram_wdata;
  logic [KW-1:0]   hram_raddr;
  logic [HW-1:0]   h_ram, p_ram, h_cur, p_cur, h_new, p_new;

  logic [HW+CHAR_W-1:0] prod_cp;
  logic [HW+BASE_W-1:0] prod_pb;
  logic [DVD_W-1:0]     dvd_h, dvd_p;

  logic              busy_h, busy_p;
  logic [SIZE_W-1:0] rem_h, rem_p;

  logic          fram_we, fram_wdata, fram_rdata;
  logic [AW-1:0] fram_waddr, fram_raddr;

  // effective configuration
  always_comb begin
    if (filter_size == '0) begin
      eff_m = SIZE_W'(1);
    end else if (32'(filter_size) > 32'(MAX_FILTER_BITS)) begin
      eff_m = SIZE_W'(MAX_FILTER_BITS);
    end else begin
      eff_m = filter_size;
    end
    if (hash_count == '0) begin
      eff_cnt = COUNT_W'(1);
    end else if (32'(hash_count) > 32'(MAX_HASHES)) begin
      eff_cnt = COUNT_W'(MAX_HASHES);
    end else begin
      eff_cnt = hash_count;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    wb         = 1'b0;
    mod_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MAX_FILTER_BITS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          accept     = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_GO;
      end
      ST_GO: begin
        mod_start  = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        if (!busy_h) begin
          wb = 1'b1;
          if (!k_last) begin
            state_next = ST_MUL;
          end else if (lst) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DONE: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (op == OP_INSERT) begin
          state_next = ST_IDLE;
        end else if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  assign k_inc   = k + 1'b1;
  assign k_last  = (k == KW'(MAX_HASHES - 1));
  assign use_k   = (COUNT_W'(k) < eff_cnt);
  assign fil_hit = wb && lst && use_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      k           <= '0;
      fresh       <= 1'b1;
      chk_pend    <= 1'b0;
      out_valid   <= 1'b0;
      filter_size <= RST_FILTER_SIZE;
      hash_count  <= RST_HASH_COUNT;
      base[0]     <= RST_BASE_ZERO;
      base[1]     <= RST_BASE_ONE;
      base[2]     <= RST_BASE_TWO;
      base[3]     <= RST_BASE_THREE;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      chk_pend <= fil_hit && (op == OP_QUERY);
      if (chk_pend && !fram_rdata) begin
        all_set <= 1'b0;
      end
      if (accept) begin
        op      <= opcode;
        chr     <= char_code;
        lst     <= last_char;
        all_set <= 1'b1;
      end
      if (wb) begin
        k <= k_last ? '0 : k_inc;
        if (k_last) begin
          fresh <= lst;
        end
      end
      if (load_out) begin
        out_valid     <= 1'b1;
        maybe_present <= all_set;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FILTER_SIZE: filter_size <= cfg_data[SIZE_W-1:0];
          REG_HASH_COUNT:  hash_count  <= cfg_data[COUNT_W-1:0];
          REG_BASE_ZERO:   base[0]     <= cfg_data[BASE_W-1:0];
          REG_BASE_ONE:    base[1]     <= cfg_data[BASE_W-1:0];
          REG_BASE_TWO:    base[2]     <= cfg_data[BASE_W-1:0];
          REG_BASE_THREE:  base[3]     <= cfg_data[BASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // hash state memory: {running hash, running power} per hash function
  assign {h_ram, p_ram} = hram_rdata;
  assign h_cur      = fresh ? '0 : h_ram;
  assign p_cur      = fresh ? HW'(1) : p_ram;
  assign h_new      = rem_h[HW-1:0];
  assign p_new      = rem_p[HW-1:0];
  assign hram_wdata = {h_new, p_new};
  assign hram_raddr = wb ? (k_last ? '0 : k_inc) : k;

  bfph_ram #(
    .WIDTH (2 * HW),
    .DEPTH (MAX_HASHES)
  ) u_hash_ram (
    .clk   (clk),
    .we    (wb),
    .waddr (k),
    .wdata (hram_wdata),
    .raddr (hram_raddr),
    .rdata (hram_rdata)
  );

  // multiply stage
  assign prod_cp = chr * p_cur;
  assign prod_pb = p_cur * base[2'(k)];

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      dvd_h <= DVD_W'(h_cur) + DVD_W'(prod_cp);
      dvd_p <= DVD_W'(prod_pb);
    end
  end

  bfph_mod #(
    .DVD_W (DVD_W)
  ) u_mod_hash (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (dvd_h),
    .modulus   (eff_m),
    .busy      (busy_h),
    .remainder (rem_h)
  );

  bfph_mod #(
    .DVD_W (DVD_W)
  ) u_mod_power (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (dvd_p),
    .modulus   (eff_m),
    .busy      (busy_p),
    .remainder (rem_p)
  );

  // filter bit memory
  assign fram_we    = (state == ST_CLEAR) || (fil_hit && (op == OP_INSERT) && !busy_p);
  assign fram_waddr = (state == ST_CLEAR) ? clr_addr : AW'(h_new);
  assign fram_wdata = (state != ST_CLEAR);
  assign fram_raddr = AW'(h_new);

  bfph_ram #(
    .WIDTH (1),
    .DEPTH (MAX_FILTER_BITS)
  ) u_filter_ram (
    .clk   (clk),
    .we    (fram_we),
    .waddr (fram_waddr),
    .wdata (fram_wdata),
    .raddr (fram_raddr),
    .rdata (fram_rdata)
  );

endmodule

// ----- dv/bloom_filter_poly_hash_tb.sv -----
// bloom_filter_poly_hash_tb: self-checking testbench of the string bloom filter
`timescale 1ns / 100ps

module bloom_filter_poly_hash_tb import bfph_pkg::*; ();

  localparam int unsigned FILTER_BITS = DEF_MAX_FILTER_BITS;
  localparam int unsigned HASHES      = DEF_MAX_HASHES;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          MAX_LEN     = 48;
  localparam int          LIB_DEPTH   = 32;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   opcode = OP_INSERT;
  logic [CHAR_W-1:0]      char_code = '0;
  logic                   last_char = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   maybe_present;

  bloom_filter_poly_hash dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .char_code     (char_code),
    .last_char     (last_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .maybe_present (maybe_present)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit                 filter_model [0:FILTER_BITS-1];
  logic [15:0]        run_hash [0:HASHES-1];
  logic [15:0]        run_pow [0:HASHES-1];
  logic [SIZE_W-1:0]  size_reg = RST_FILTER_SIZE;
  logic [COUNT_W-1:0] count_reg = RST_HASH_COUNT;
  logic [BASE_W-1:0]  base_reg [0:NUM_BASES-1];
  logic               presence_q [$];

  int  err_count = 0;
  bit  idle_on = 1'b1;
  int  hold_cycles = 0;

  logic [CHAR_W-1:0] str_buf [0:MAX_LEN-1];
  int                str_len = 0;
  logic [CHAR_W-1:0] lib_chars [0:LIB_DEPTH-1][0:MAX_LEN-1];
  int                lib_len [0:LIB_DEPTH-1];
  int                lib_fill = 0;

  initial begin
    for (int i = 0; i < FILTER_BITS; i++) filter_model[i] = 1'b0;
    for (int k = 0; k < HASHES; k++) begin
      run_hash[k] = '0;
      run_pow[k]  = 16'd1;
    end
    base_reg[0] = RST_BASE_ZERO;
    base_reg[1] = RST_BASE_ONE;
    base_reg[2] = RST_BASE_TWO;
    base_reg[3] = RST_BASE_THREE;
  end

  function automatic void hash_and_probe(input logic op, input logic [CHAR_W-1:0] ch,
                                         input logic last);
    longint unsigned m;
    longint unsigned h;
    longint unsigned p;
    int unsigned     cnt;
    int unsigned     idx;
    logic            all_set;
    m = (size_reg == 0) ? 1 : ((size_reg > FILTER_BITS) ? FILTER_BITS : size_reg);
    for (int k = 0; k < HASHES; k++) begin
      h = run_hash[k];
      p = run_pow[k];
      h = (h + ch * p) % m;
      p = (p * base_reg[k]) % m;
      run_hash[k] = 16'(h);
      run_pow[k]  = 16'(p);
    end
    if (last) begin
      cnt = (count_reg == 0) ? 1 : ((count_reg > HASHES) ? HASHES : count_reg);
      all_set = 1'b1;
      for (int k = 0; k < cnt; k++) begin
        idx = int'(run_hash[k] % m);
        if (op == OP_INSERT) filter_model[idx] = 1'b1;
        else if (!filter_model[idx]) all_set = 1'b0;
      end
      for (int k = 0; k < HASHES; k++) begin
        run_hash[k] = '0;
        run_pow[k]  = 16'd1;
      end
      if (op == OP_QUERY) presence_q.push_back(all_set);
    end
  endfunction

  task automatic send_char(input logic op, input logic [CHAR_W-1:0] ch, input logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    char_code <= ch;
    last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_and_probe(op, ch, last);
  endtask

  // only the opcode of the last character counts, so the others are random
  task automatic send_string(input logic op);
    logic last;
    for (int i = 0; i < str_len; i++) begin
      last = (i == str_len - 1);
      send_char(last ? op : logic'($urandom_range(0, 1)), str_buf[i], last);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (presence_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    case (idx)
      REG_FILTER_SIZE: size_reg = data[SIZE_W-1:0];
      REG_HASH_COUNT:  count_reg = data[COUNT_W-1:0];
      REG_BASE_ZERO:   base_reg[0] = data[BASE_W-1:0];
      REG_BASE_ONE:    base_reg[1] = data[BASE_W-1:0];
      REG_BASE_TWO:    base_reg[2] = data[BASE_W-1:0];
      REG_BASE_THREE:  base_reg[3] = data[BASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_setting(input int unsigned fsize, input int unsigned cnt,
                               input int unsigned b0, input int unsigned b1,
                               input int unsigned b2, input int unsigned b3);
    settle();
    write_reg(REG_FILTER_SIZE, fsize);
    write_reg(REG_HASH_COUNT, cnt);
    write_reg(REG_BASE_ZERO, b0);
    write_reg(REG_BASE_ONE, b1);
    write_reg(REG_BASE_TWO, b2);
    write_reg(REG_BASE_THREE, b3);
    close_cfg();
  endtask

  task automatic make_random_string();
    str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_LEN) : $urandom_range(1, 6);
    for (int i = 0; i < str_len; i++) str_buf[i] = CHAR_W'($urandom_range(0, 255));
  endtask

  task automatic run_mix(input int n_chars);
    int sent;
    int pick;
    int slot;
    sent = 0;
    while (sent < n_chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || lib_fill == 0) begin
        make_random_string();
        send_string(OP_INSERT);
        if (lib_fill < LIB_DEPTH) begin
          slot = lib_fill;
          lib_fill++;
        end else begin
          slot = $urandom_range(0, LIB_DEPTH - 1);
        end
        lib_len[slot] = str_len;
        for (int i = 0; i < str_len; i++) lib_chars[slot][i] = str_buf[i];
      end else if (pick < 80) begin
        slot = $urandom_range(0, lib_fill - 1);
        str_len = lib_len[slot];
        for (int i = 0; i < str_len; i++) str_buf[i] = lib_chars[slot][i];
        send_string(OP_QUERY);
      end else begin
        make_random_string();
        send_string(OP_QUERY);
      end
      sent += str_len;
    end
  endtask

  // reset register values, byte extremes, opcode taken from the last character
  task automatic test_reset_values();
    str_len = 1;
    str_buf[0] = 8'h00;
    send_string(OP_QUERY);
    send_string(OP_INSERT);
    send_string(OP_QUERY);
    str_len = 3;
    str_buf[0] = 8'hFF;
    str_buf[1] = 8'h80;
    str_buf[2] = 8'h01;
    send_char(OP_QUERY, str_buf[0], 1'b0);
    send_char(OP_QUERY, str_buf[1], 1'b0);
    send_char(OP_INSERT, str_buf[2], 1'b1);
    send_char(OP_INSERT, str_buf[0], 1'b0);
    send_char(OP_INSERT, str_buf[1], 1'b0);
    send_char(OP_QUERY, str_buf[2], 1'b1);
    str_buf[2] = 8'h02;
    send_string(OP_QUERY);
  endtask

  // zero size and count, then saturated size and count with extreme bases
  task automatic test_config_extremes();
    apply_setting(0, 0, 32'(RST_BASE_ZERO), 32'(RST_BASE_ONE), 32'(RST_BASE_TWO),
                  32'(RST_BASE_THREE));
    str_len = 1;
    str_buf[0] = 8'h41;
    send_string(OP_INSERT);
    str_buf[0] = 8'h5A;
    send_string(OP_QUERY);
    apply_setting(131071, 7, 0, 65535, 65535, 0);
    str_len = 2;
    str_buf[0] = 8'h7F;
    str_buf[1] = 8'hC3;
    send_string(OP_INSERT);
    send_string(OP_QUERY);
    str_buf[1] = 8'h3C;
    send_string(OP_QUERY);
  endtask

  task automatic test_mid_string_config();
    settle();
    send_char(OP_INSERT, 8'h55, 1'b0);
    send_char(OP_QUERY, 8'hAA, 1'b0);
    settle();
    write_reg(REG_FILTER_SIZE, 1000);
    write_reg(REG_BASE_TWO, 7);
    close_cfg();
    send_char(OP_QUERY, 8'h0F, 1'b1);
  endtask

  // receiver holds off while queries keep coming, so the input backs up
  task automatic test_backpressure();
    settle();
    hold_cycles = 400;
    str_len = 1;
    for (int i = 0; i < 20; i++) begin
      str_buf[0] = CHAR_W'($urandom_range(0, 255));
      send_string(OP_QUERY);
    end
    settle();
  endtask

  task automatic test_random_mix();
    apply_setting(65536, 4, 31, 37, 41, 43);
    run_mix(250);
    apply_setting(97, 3, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_mix(250);
    apply_setting(1, 7, 65535, 0, 1, 2);
    run_mix(200);
    apply_setting(131071, 0, 0, 65535, 65535, 0);
    run_mix(250);
    apply_setting(2, 2, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_mix(200);
    apply_setting($urandom_range(1, 4096), $urandom_range(0, 7), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_mix(250);
    idle_on = 1'b0;
    apply_setting($urandom_range(3, 300), 4, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_mix(150);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic want;
    if (!rst && out_valid && !out_stall) begin
      if (presence_q.size() == 0) begin
        $error("maybe_present: no request pending, actual %0b", maybe_present);
        err_count++;
      end else begin
        want = presence_q.pop_front();
        if (want !== maybe_present) begin
          $error("maybe_present: expected %0b, actual %0b", want, maybe_present);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_config_extremes();
    test_mid_string_config();
    test_backpressure();
    test_random_mix();
    settle();
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bfph_pkg.sv
rtl/core/bfph_ram.sv
rtl/core/bfph_mod.sv
rtl/core/bloom_filter_poly_hash.sv
dv/bloom_filter_poly_hash_tb.sv
